// ===== rtl/core/quarter_round_matrix_permute_assert.svh =====
// assertion macros shared by the permutation block
// no dependencies; included by modules that carry assertions
`ifndef QUARTER_ROUND_MATRIX_PERMUTE_ASSERT_SVH
`define QUARTER_ROUND_MATRIX_PERMUTE_ASSERT_SVH

// condition holds at every edge outside reset
`define QRMP_ASSERT_NOW(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define QRMP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define QRMP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/qrmp_pkg.sv =====
// types, constants and helper functions of the quarter round permutation block
// no dependencies
`default_nettype none

package qrmp_pkg;

   typedef logic [31:0] word_type;
   typedef logic [3:0]  index_type;

   localparam index_type LAST_INDEX = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_COL,
      PH_ROW,
      PH_DIAG
   } phase_type;

   // lane positions per phase: [phase][lane][a,b,c,d]
   localparam index_type LANE_MAP [3][4][4] = '{
      '{'{4'd0, 4'd4, 4'd8,  4'd12}, '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}},
      '{'{4'd0, 4'd1, 4'd2,  4'd3},  '{4'd4, 4'd5, 4'd6,  4'd7},
        '{4'd8, 4'd9, 4'd10, 4'd11}, '{4'd12, 4'd13, 4'd14, 4'd15}},
      '{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13}, '{4'd3, 4'd4, 4'd9,  4'd14}}
   };

   typedef struct packed {
      logic      load;
      logic      step;
      phase_type phase;
      logic [1:0] qstep;
      logic      emit;
      index_type emit_index;
   } cmd_type;

   typedef struct packed {
      logic start_index;
   } sts_type;

   // fixed rotation of each quarter round step: 16, 12, 8, 7
   function automatic word_type rotl_step(input word_type v, input logic [1:0] qs);
      word_type r;
      case (qs)
         2'd0:    r = {v[15:0], v[31:16]};
         2'd1:    r = {v[19:0], v[31:20]};
         2'd2:    r = {v[23:0], v[31:24]};
         2'd3:    r = {v[24:0], v[31:25]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qrmp_req_if.sv =====
// request channel: matrix word and its index with valid/ready handshake
// no dependencies
`default_nettype none

interface qrmp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_word;
   logic [3:0]  in_index;

   modport source (output valid, output in_word, output in_index, input ready);
   modport sink   (input valid, input in_word, input in_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qrmp_rsp_if.sv =====
// response channel: permuted word, index and last flag with valid/ready handshake
// no dependencies
`default_nettype none

interface qrmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic [3:0]  out_index;
   logic        out_last;

   modport source (output valid, output out_word, output out_index, output out_last,
                   input ready);
   modport sink   (input valid, input out_word, input out_index, input out_last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qrmp_datapath.sv =====
// matrix storage, four quarter round lanes and the response word register
// depends on qrmp_pkg
`default_nettype none

module qrmp_datapath
   import qrmp_pkg::*;
(
   input  wire logic      clock,
   input  wire cmd_type   cmd,
   output sts_type        sts,
   input  wire word_type  req_word,
   input  wire index_type req_index,
   output word_type       rsp_word,
   output index_type      rsp_index,
   output logic           rsp_last
);

   word_type  m_ff [16];
   word_type  m_in [16];
   word_type  quad [4][4];
   word_type  quad_new [4][4];
   word_type  sum [4];
   word_type  mix [4];
   word_type  out_word_ff, out_word_in;
   index_type out_index_ff, out_index_in;
   logic      out_last_ff, out_last_in;

   assign sts.start_index = (req_index == LAST_INDEX);

   // gather the four lanes of the current phase
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         for (int k = 0; k < 4; k++) begin
            quad[g][k] = m_ff[LANE_MAP[0][g][k]];
         end
      end
      case (cmd.phase)
         PH_ROW: begin
            for (int g = 0; g < 4; g++) begin
               for (int k = 0; k < 4; k++) begin
                  quad[g][k] = m_ff[LANE_MAP[1][g][k]];
               end
            end
         end
         PH_DIAG: begin
            for (int g = 0; g < 4; g++) begin
               for (int k = 0; k < 4; k++) begin
                  quad[g][k] = m_ff[LANE_MAP[2][g][k]];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // one add-xor-rotate step per lane; odd steps work on c,d -> b
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         quad_new[g] = quad[g];
         if (cmd.qstep[0]) begin
            sum[g] = quad[g][2] + quad[g][3];
            mix[g] = rotl_step(quad[g][1] ^ sum[g], cmd.qstep);
            quad_new[g][2] = sum[g];
            quad_new[g][1] = mix[g];
         end else begin
            sum[g] = quad[g][0] + quad[g][1];
            mix[g] = rotl_step(quad[g][3] ^ sum[g], cmd.qstep);
            quad_new[g][0] = sum[g];
            quad_new[g][3] = mix[g];
         end
      end
   end

   // scatter back, or store a loaded word
   always_comb begin
      m_in = m_ff;
      if (cmd.step) begin
         case (cmd.phase)
            PH_ROW: begin
               for (int g = 0; g < 4; g++) begin
                  for (int k = 0; k < 4; k++) begin
                     m_in[LANE_MAP[1][g][k]] = quad_new[g][k];
                  end
               end
            end
            PH_DIAG: begin
               for (int g = 0; g < 4; g++) begin
                  for (int k = 0; k < 4; k++) begin
                     m_in[LANE_MAP[2][g][k]] = quad_new[g][k];
                  end
               end
            end
            default: begin
               for (int g = 0; g < 4; g++) begin
                  for (int k = 0; k < 4; k++) begin
                     m_in[LANE_MAP[0][g][k]] = quad_new[g][k];
                  end
               end
            end
         endcase
      end
      if (cmd.load) begin
         m_in[req_index] = req_word;
      end
   end

   always_comb begin
      out_word_in  = out_word_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_word_in  = m_ff[cmd.emit_index];
         out_index_in = cmd.emit_index;
         out_last_in  = (cmd.emit_index == LAST_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      out_word_ff  <= out_word_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_word  = out_word_ff;
   assign rsp_index = out_index_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/qrmp_ctrl.sv =====
// sequencer: load handshake, round/phase/step counters and response valid
// depends on qrmp_pkg and the assertion macro header
`default_nettype none
`include "quarter_round_matrix_permute_assert.svh"

module qrmp_ctrl
   import qrmp_pkg::*;
#(
   parameter int ROUND_COUNT = 20
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam int IterW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
   localparam logic [IterW-1:0] IterLast = IterW'(ROUND_COUNT - 1);

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic [1:0]       qstep_ff, qstep_in;
   index_type        out_cnt_ff, out_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             round_end;
   logic             last_step;
   logic             emit_go;
   logic             counters_zero;
   logic             emit_done;

   assign round_end = (qstep_ff == 2'd3) && (phase_ff == PH_DIAG);
   assign last_step = round_end && (iter_ff == IterLast);
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign counters_zero = (qstep_ff == 2'd0) && (phase_ff == PH_COL) && (iter_ff == '0);
   assign emit_done     = emit_go && (out_cnt_ff == LAST_INDEX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.start_index) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_step) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go && (out_cnt_ff == LAST_INDEX)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.load       = req_valid && (state_ff == ST_IDLE);
      cmd.step       = (state_ff == ST_RUN);
      cmd.phase      = phase_ff;
      cmd.qstep      = qstep_ff;
      cmd.emit       = emit_go;
      cmd.emit_index = out_cnt_ff;
      rsp_valid      = rsp_valid_ff;
   end

   always_comb begin
      qstep_in = qstep_ff;
      phase_in = phase_ff;
      iter_in  = iter_ff;
      if (state_ff == ST_RUN) begin
         qstep_in = qstep_ff + 2'd1;
         if (qstep_ff == 2'd3) begin
            case (phase_ff)
               PH_COL:  phase_in = PH_ROW;
               PH_ROW:  phase_in = PH_DIAG;
               default: phase_in = PH_COL;
            endcase
         end
         if (round_end) iter_in = last_step ? '0 : iter_ff + 1'b1;
      end
      out_cnt_in   = emit_go ? out_cnt_ff + 4'd1 : out_cnt_ff;
      rsp_valid_in = emit_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_COL;
         iter_ff      <= '0;
         qstep_ff     <= 2'd0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
         qstep_ff     <= qstep_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // counters rest at zero whenever no permutation runs
   `QRMP_ASSERT_NOW(a_counters_rest, clock, reset, (state_ff == ST_RUN) || counters_zero)
   `QRMP_ASSERT_NXT(a_run_to_emit, clock, reset, last_step, (state_ff == ST_EMIT) && ~|out_cnt_ff)
   `QRMP_ASSERT_NXT(a_emit_done, clock, reset, emit_done, req_ready && rsp_valid && ~|out_cnt_ff)

endmodule

`default_nettype wire

// ===== rtl/core/quarter_round_matrix_permute.sv =====
// top level of the quarter round matrix permutation block
// depends on qrmp_pkg, qrmp_req_if, qrmp_rsp_if, qrmp_ctrl and qrmp_datapath
`default_nettype none

// Loads a 4x4 matrix of 32-bit words, one word per cycle at index 4*row+column;
// the word at index 15 starts ROUND_COUNT iterations of column, row and diagonal
// quarter rounds (no feed-forward). The four quarter round lanes each do one
// add-xor-rotate step per cycle; during the permutation no word is taken. The
// sixteen words then leave in index order, one per cycle while rsp is ready,
// the last marked; new words are taken again as soon as the last one sits in
// the output register.
module quarter_round_matrix_permute
   import qrmp_pkg::*;
#(
   parameter int ROUND_COUNT = 20
) (
   input  wire logic   clock,
   input  wire logic   reset,
   qrmp_req_if.sink    req_chan,
   qrmp_rsp_if.source  rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   qrmp_ctrl #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qrmp_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_chan.in_word),
      .req_index (req_chan.in_index),
      .rsp_word  (rsp_chan.out_word),
      .rsp_index (rsp_chan.out_index),
      .rsp_last  (rsp_chan.out_last)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench of the quarter round matrix permutation block: loads 4x4 word matrices,
// predicts the permuted matrix in a scoreboard and checks every response word in order
// depends on qrmp_pkg, qrmp_req_if, qrmp_rsp_if and quarter_round_matrix_permute
module testbench;
   import qrmp_pkg::*;

   localparam int ROUNDS      = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 12 * ROUNDS + 64;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 56;
   localparam int IDLE_PCT    = 21;
   localparam int WORD_TARGET = 130;

   typedef struct packed {
      word_type  word;
      index_type index;
      logic      last;
   } out_word_type;

   class permute_scoreboard;
      word_type     matrix [16];
      out_word_type expected_q [$];
      int           mismatches;
      int           words_checked;

      function word_type rotl(word_type v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void mix(int ia, int ib, int ic, int id);
         word_type a, b, c, d;
         a = matrix[ia];
         b = matrix[ib];
         c = matrix[ic];
         d = matrix[id];
         a += b; d ^= a; d = rotl(d, 16);
         c += d; b ^= c; b = rotl(b, 12);
         a += b; d ^= a; d = rotl(d, 8);
         c += d; b ^= c; b = rotl(b, 7);
         matrix[ia] = a;
         matrix[ib] = b;
         matrix[ic] = c;
         matrix[id] = d;
      endfunction

      function void permute();
         for (int it = 0; it < ROUNDS; it++)
            for (int s = 0; s < 3; s++)
               for (int g = 0; g < 4; g++)
                  case (phase_type'(s))
                     PH_COL:  mix(g, g + 4, g + 8, g + 12);
                     PH_ROW:  mix(4 * g, 4 * g + 1, 4 * g + 2, 4 * g + 3);
                     // wrapped diagonal: row r takes column (g + r) mod 4
                     PH_DIAG: mix(g, 4 + ((g + 1) & 3), 8 + ((g + 2) & 3),
                                  12 + ((g + 3) & 3));
                     default: ;
                  endcase
      endfunction

      function void note_word(word_type w, index_type ix);
         out_word_type e;
         matrix[ix] = w;
         if (ix == LAST_INDEX) begin
            permute();
            for (int k = 0; k < 16; k++) begin
               e.word  = matrix[k];
               e.index = index_type'(k);
               e.last  = (k == 15);
               expected_q.push_back(e);
            end
         end
      endfunction

      function void report(string what, out_word_type e, out_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at response word %0d (%s): expected %h/%0d/%b got %h/%0d/%b",
                     words_checked, what, e.word, e.index, e.last,
                     got.word, got.index, got.last);
      endfunction

      function void check_result(out_word_type got);
         out_word_type e;
         words_checked++;
         if (expected_q.size() == 0) begin
            e = '0;
            report("unexpected word", e, got);
            return;
         end
         e = expected_q.pop_front();
         if (got.word !== e.word)
            report("word", e, got);
         else if (got.index !== e.index)
            report("index", e, got);
         else if (got.last !== e.last)
            report("last", e, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycles;
   int   words_sent;
   bit   sender_steady;
   permute_scoreboard sb = new();

   qrmp_req_if req_chan ();
   qrmp_rsp_if rsp_chan ();

   quarter_round_matrix_permute #(.ROUND_COUNT(ROUNDS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic word_type pick_word();
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      return $urandom;
   endfunction

   task automatic send_word(input word_type w, input index_type ix);
      while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.in_word  <= w;
      req_chan.in_index <= ix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_word(w, ix);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // response side: random backpressure, one long hold, and a steady stretch
   initial begin
      int  hold_left;
      bit  hold_done;
      bit  steady;
      rsp_chan.ready = 1'b0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result('{rsp_chan.out_word, rsp_chan.out_index, rsp_chan.out_last});
         if (!hold_done && sb.words_checked >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         steady = (sb.words_checked >= 100 && sb.words_checked < 150);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      index_type order [15];
      index_type t;
      int        r, n, j;
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.in_word  = '0;
      req_chan.in_index = '0;
      sender_steady = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full first load with extreme and patterned words
      send_word(32'h0000_0000, 4'd0);
      send_word(32'hFFFF_FFFF, 4'd1);
      send_word(32'h8000_0000, 4'd2);
      send_word(32'h0000_0001, 4'd3);
      send_word(32'h7FFF_FFFF, 4'd4);
      send_word(32'hAAAA_AAAA, 4'd5);
      send_word(32'h5555_5555, 4'd6);
      send_word(32'hFFFF_0000, 4'd7);
      send_word(32'h0000_FFFF, 4'd8);
      send_word(32'hFFFF_FFFF, 4'd9);
      send_word(32'h0000_0000, 4'd10);
      send_word(32'h8000_0001, 4'd11);
      send_word(32'hFFFF_FFFE, 4'd12);
      send_word(32'h0F0F_0F0F, 4'd13);
      send_word(32'hF0F0_F0F0, 4'd14);
      send_word(32'hFFFF_FFFF, LAST_INDEX);
      // permute the previous result again, only the last word rewritten
      send_word(32'h0000_0000, LAST_INDEX);
      // partial rewrite mixed with kept permuted words
      send_word(32'hFFFF_FFFF, 4'd0);
      send_word(32'h0000_0000, 4'd10);
      send_word(32'h1234_5678, LAST_INDEX);
      wait_drained();

      while (words_sent < WORD_TARGET) begin
         sender_steady = (words_sent >= 60 && words_sent < 95);
         r = $urandom_range(99);
         if (r < 65) begin
            // fresh matrix, sometimes in shuffled order, start word last
            for (int k = 0; k < 15; k++) order[k] = index_type'(k);
            if ($urandom_range(1) == 1) begin
               for (int k = 14; k > 0; k--) begin
                  j = $urandom_range(k);
                  t = order[k];
                  order[k] = order[j];
                  order[j] = t;
               end
            end
            for (int k = 0; k < 15; k++) send_word(pick_word(), order[k]);
            send_word(pick_word(), LAST_INDEX);
         end else if (r < 85) begin
            n = $urandom_range(5);
            repeat (n) send_word(pick_word(), index_type'($urandom_range(14)));
            send_word(pick_word(), LAST_INDEX);
         end else begin
            // stray writes, a start among them now and then
            n = $urandom_range(4, 1);
            repeat (n) send_word(pick_word(), index_type'($urandom_range(15)));
         end
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
